[hdl/bed_pkg.sv]
// Shared types and constants of the button event detector.
package bed_pkg;

   localparam int NUM_BUTTONS = 8;
   localparam int COUNT_BITS  = 16;

   // At most eight results are produced per tick.
   localparam int RESULT_LIMIT = 8;
   localparam int EFF_BUTTONS  = (NUM_BUTTONS < RESULT_LIMIT) ? NUM_BUTTONS : RESULT_LIMIT;
   localparam int IDX_W        = (EFF_BUTTONS > 1) ? $clog2(EFF_BUTTONS) : 1;

   // Width used when comparing the tick counter with the 16-bit thresholds.
   localparam int THRESH_W = 16;
   localparam int CMP_W    = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   localparam logic [2:0] CSR_PRESSED_MASK = 3'd0;
   localparam logic [2:0] CSR_BUTTON_COUNT = 3'd1;
   localparam logic [2:0] CSR_SHORT_TICKS  = 3'd2;
   localparam logic [2:0] CSR_LONG_TICKS   = 3'd3;
   localparam logic [2:0] CSR_HOLD_TICKS   = 3'd4;
   localparam logic [2:0] CSR_GAP_TICKS    = 3'd5;

   typedef logic [IDX_W-1:0]      bed_idx_type;
   typedef logic [COUNT_BITS-1:0] bed_cnt_type;
   typedef logic [COUNT_BITS:0]   bed_cntx_type;
   typedef logic [CMP_W-1:0]      bed_cmp_type;

   // One button's work for one tick.
   typedef struct packed {
      bed_idx_type idx;
      logic        pressed;
      logic        first;
      logic        last;
   } bed_job_type;

   // Timing thresholds used by the event logic.
   typedef struct packed {
      logic [THRESH_W-1:0] short_press_ticks;
      logic [THRESH_W-1:0] long_press_ticks;
      logic [THRESH_W-1:0] long_hold_ticks;
      logic [THRESH_W-1:0] click_gap_ticks;
   } bed_cfg_type;

endpackage

[hdl/bed_front.sv]
// Front end: accepts scan ticks and issues one job per enabled button.
module bed_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic [7:0]            pressed_mask,
   input  logic [3:0]            button_count,
   output logic                  push,
   output bed_pkg::bed_job_type  push_job,
   input  logic                  queue_full
);

   typedef enum logic {
      FR_IDLE,
      FR_ISSUE
   } front_state_type;

   localparam logic [3:0] EFF_COUNT = 4'(bed_pkg::EFF_BUTTONS);

   front_state_type                 state_ff;
   bed_pkg::bed_idx_type            idx_ff;
   logic                            first_ff;
   logic [bed_pkg::EFF_BUTTONS-1:0] pressed_ff;

   logic [3:0] n_enabled;
   logic [7:0] pressed_bits;
   logic       accept;

   assign n_enabled    = (button_count > EFF_COUNT) ? EFF_COUNT : button_count;
   assign pressed_bits = ~(req_tdata ^ pressed_mask);
   assign req_tready   = (state_ff == FR_IDLE);
   assign accept       = req_tvalid && req_tready;

   assign push              = (state_ff == FR_ISSUE) && !queue_full;
   assign push_job.idx      = idx_ff;
   assign push_job.pressed  = pressed_ff[idx_ff];
   assign push_job.first    = first_ff;
   assign push_job.last     = (idx_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         idx_ff   <= '0;
         first_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            FR_IDLE: begin
               // A tick with no enabled buttons is taken and dropped.
               if (accept && (n_enabled != 4'd0)) begin
                  state_ff   <= FR_ISSUE;
                  idx_ff     <= bed_pkg::bed_idx_type'(n_enabled - 4'd1);
                  first_ff   <= 1'b1;
                  pressed_ff <= pressed_bits[bed_pkg::EFF_BUTTONS-1:0];
               end
            end
            FR_ISSUE: begin
               if (push) begin
                  first_ff <= 1'b0;
                  if (idx_ff == '0) begin
                     state_ff <= FR_IDLE;
                  end else begin
                     idx_ff <= idx_ff - 1'b1;
                  end
               end
            end
            default: state_ff <= FR_IDLE;
         endcase
      end
   end

endmodule

[hdl/bed_queue.sv]
// Short job queue between the front end and the event engine.
module bed_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bed_pkg::bed_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output bed_pkg::bed_job_type pop_job,
   output logic                 not_empty
);

   bed_pkg::bed_job_type slot_ff [bed_pkg::QUEUE_DEPTH];
   logic [bed_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [bed_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [bed_pkg::QPTR_W:0]   fill_ff;

   assign full      = (fill_ff == (bed_pkg::QPTR_W + 1)'(bed_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push && !full) begin
            slot_ff[wr_ptr_ff] <= push_job;
            wr_ptr_ff          <= wr_ptr_ff + 1'b1;
         end
         if (pop && not_empty) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         priority if ((push && !full) && !(pop && not_empty)) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (!(push && !full) && (pop && not_empty)) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

[hdl/bed_back.sv]
// Event engine: one button per cycle while not stalled; registers each result.
module bed_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bed_pkg::bed_cfg_type cfg,
   input  logic                 job_valid,
   input  bed_pkg::bed_job_type job,
   output logic                 job_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   output logic                 rsp_tlast
);

   typedef enum logic [1:0] {
      ST_UP    = 2'd0,
      ST_DOWN  = 2'd1,
      ST_MULTI = 2'd2
   } stage_type;

   localparam logic [3:0] EV_NONE        = 4'd0;
   localparam logic [3:0] EV_DOWN        = 4'd1;
   localparam logic [3:0] EV_REPEAT      = 4'd4;
   localparam logic [3:0] EV_SHORT_START = 4'd5;
   localparam logic [3:0] EV_SHORT_UP    = 4'd6;
   localparam logic [3:0] EV_LONG_START  = 4'd7;
   localparam logic [3:0] EV_LONG_UP     = 4'd8;
   localparam logic [3:0] EV_HOLD        = 4'd9;
   localparam logic [3:0] EV_HOLD_UP     = 4'd10;

   localparam bed_pkg::bed_cnt_type CNT_MAX = '1;

   stage_type            stage_ff [bed_pkg::EFF_BUTTONS];
   bed_pkg::bed_cnt_type tick_ff  [bed_pkg::EFF_BUTTONS];
   logic [7:0]           click_ff [bed_pkg::EFF_BUTTONS];
   logic [3:0]           event_ff [bed_pkg::EFF_BUTTONS];

   logic [3:0] active_ff;
   logic       rsp_valid_ff;
   logic [2:0] rsp_idx_ff;
   logic [3:0] rsp_code_ff;
   logic       rsp_fired_ff;
   logic [3:0] rsp_active_ff;
   logic       rsp_last_ff;

   stage_type            cur_stage, stage_in;
   bed_pkg::bed_cnt_type cur_tick, tick_in;
   logic [7:0]           cur_click, click_in;
   logic [3:0]           cur_event, event_in, want, click_code;
   bed_pkg::bed_cntx_type tick_inc;
   bed_pkg::bed_cmp_type  t_cmp;
   logic       fired;
   logic       ge_hold, ge_long, ge_short, gt_gap;
   logic [3:0] active_base, active_sum;

   assign job_pop = job_valid && (!rsp_valid_ff || rsp_tready);

   assign cur_stage = stage_ff[job.idx];
   assign cur_tick  = tick_ff[job.idx];
   assign cur_click = click_ff[job.idx];
   assign cur_event = event_ff[job.idx];

   assign tick_inc = bed_pkg::bed_cntx_type'(cur_tick) + bed_pkg::bed_cntx_type'(1);

   always_comb begin
      stage_in = cur_stage;
      tick_in  = cur_tick;
      click_in = cur_click;
      event_in = cur_event;
      fired    = 1'b0;
      want     = EV_NONE;

      // The counter runs in every stage but up, and wraps to the hold threshold.
      if (cur_stage != ST_UP) begin
         if (tick_inc >= bed_pkg::bed_cntx_type'(CNT_MAX)) begin
            tick_in = bed_pkg::bed_cnt_type'(cfg.long_hold_ticks);
         end else begin
            tick_in = tick_inc[bed_pkg::COUNT_BITS-1:0];
         end
      end
      t_cmp    = bed_pkg::bed_cmp_type'(tick_in);
      ge_hold  = t_cmp >= bed_pkg::bed_cmp_type'(cfg.long_hold_ticks);
      ge_long  = t_cmp >= bed_pkg::bed_cmp_type'(cfg.long_press_ticks);
      ge_short = t_cmp >= bed_pkg::bed_cmp_type'(cfg.short_press_ticks);
      gt_gap   = t_cmp >  bed_pkg::bed_cmp_type'(cfg.click_gap_ticks);

      // One or two clicks give click or double, three and more give repeat.
      click_code = (cur_click < 8'd3) ? (cur_click[3:0] + 4'd1) : EV_REPEAT;

      unique case (cur_stage)
         ST_UP: begin
            if (job.pressed) begin
               tick_in  = '0;
               click_in = '0;
               event_in = EV_DOWN;
               fired    = 1'b1;
               stage_in = ST_DOWN;
            end else begin
               event_in = EV_NONE;
            end
         end
         ST_DOWN: begin
            if (job.pressed) begin
               if (cur_click != 8'd0) begin
                  if (gt_gap) begin
                     event_in = click_code;
                     fired    = 1'b1;
                     tick_in  = '0;
                     click_in = '0;
                  end
               end else if (ge_hold) begin
                  want = EV_HOLD;
               end else if (ge_long) begin
                  want = EV_LONG_START;
               end else if (ge_short) begin
                  want = EV_SHORT_START;
               end
               if ((want != EV_NONE) && (cur_event != want)) begin
                  event_in = want;
                  fired    = 1'b1;
               end
            end else begin
               if (ge_hold) begin
                  event_in = EV_HOLD_UP;
                  fired    = 1'b1;
                  stage_in = ST_UP;
               end else if (ge_long) begin
                  event_in = EV_LONG_UP;
                  fired    = 1'b1;
                  stage_in = ST_UP;
               end else if (ge_short) begin
                  event_in = EV_SHORT_UP;
                  fired    = 1'b1;
                  stage_in = ST_UP;
               end else begin
                  stage_in = ST_MULTI;
                  if (cur_click != 8'hFF) begin
                     click_in = cur_click + 8'd1;
                  end
               end
            end
         end
         ST_MULTI: begin
            if (job.pressed) begin
               stage_in = ST_DOWN;
               tick_in  = '0;
            end else if (gt_gap) begin
               event_in = click_code;
               fired    = 1'b1;
               stage_in = ST_UP;
            end
         end
         default: stage_in = ST_UP;
      endcase

      active_base = job.first ? 4'd0 : active_ff;
      active_sum  = active_base + ((stage_in != ST_UP) ? 4'd1 : 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bed_pkg::EFF_BUTTONS; i++) begin
            stage_ff[i] <= ST_UP;
            tick_ff[i]  <= '0;
            click_ff[i] <= '0;
            event_ff[i] <= EV_NONE;
         end
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (job_pop) begin
            stage_ff[job.idx] <= stage_in;
            tick_ff[job.idx]  <= tick_in;
            click_ff[job.idx] <= click_in;
            event_ff[job.idx] <= event_in;
            active_ff         <= active_sum;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         rsp_idx_ff    <= 3'(job.idx);
         rsp_code_ff   <= event_in;
         rsp_fired_ff  <= fired;
         rsp_active_ff <= job.last ? active_sum : 4'd0;
         rsp_last_ff   <= job.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_active_ff, rsp_fired_ff, rsp_code_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hdl/button_event_detector.sv]
// Button event detector: top level with configuration registers, front end, queue and engine.
//
// Each input transaction is one scan tick carrying the raw level of every button, and the
// block answers with one result transaction per enabled button, from the highest index
// down to button 0; the final one has tlast set and carries the number of enabled buttons
// that are not in the up stage. The front end takes a tick and then issues one button job per
// cycle into a four-entry queue while the queue is not full, and accepts the next tick only
// after the last job of the current one is pushed. The event engine behind the queue
// handles one button per cycle while the consumer keeps rsp_tready high or no result is
// pending. A tick that arrives with no buttons enabled is accepted and produces no result.
// The configuration registers are written through csr_we, csr_addr and csr_wdata; the
// user must write them only while the block is idle, which the block itself does not
// enforce. Writes to indexes above five are ignored.
module button_event_detector (
   input  logic        clock,
   input  logic        reset,
   // Tick input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raw_levels
   // Per-button results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] button_index, [6:3] event_code,
                                    // [7] event_fired, [11:8] active_count, [15:12] zero
   output logic        rsp_tlast,   // last_result
   // Configuration writes.
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   logic [7:0]           mask_ff;
   logic [3:0]           count_ff;
   bed_pkg::bed_cfg_type cfg_ff;

   logic                 push;
   bed_pkg::bed_job_type push_job;
   logic                 queue_full;
   logic                 pop;
   bed_pkg::bed_job_type pop_job;
   logic                 queue_not_empty;

   // Register file; thresholds come out of reset at their documented defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff                  <= 8'd0;
         count_ff                 <= 4'd0;
         cfg_ff.short_press_ticks <= 16'd3;
         cfg_ff.long_press_ticks  <= 16'd50;
         cfg_ff.long_hold_ticks   <= 16'd150;
         cfg_ff.click_gap_ticks   <= 16'd30;
      end else if (csr_we) begin
         unique case (csr_addr)
            bed_pkg::CSR_PRESSED_MASK: mask_ff                  <= csr_wdata[7:0];
            bed_pkg::CSR_BUTTON_COUNT: count_ff                 <= csr_wdata[3:0];
            bed_pkg::CSR_SHORT_TICKS:  cfg_ff.short_press_ticks <= csr_wdata;
            bed_pkg::CSR_LONG_TICKS:   cfg_ff.long_press_ticks  <= csr_wdata;
            bed_pkg::CSR_HOLD_TICKS:   cfg_ff.long_hold_ticks   <= csr_wdata;
            bed_pkg::CSR_GAP_TICKS:    cfg_ff.click_gap_ticks   <= csr_wdata;
            default: ;
         endcase
      end
   end

   bed_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .pressed_mask (mask_ff),
      .button_count (count_ff),
      .push         (push),
      .push_job     (push_job),
      .queue_full   (queue_full)
   );

   bed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_job   (pop_job),
      .not_empty (queue_not_empty)
   );

   bed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (queue_not_empty),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
